// ----- design/lirc_pkg.sv -----
// Shared constants and types for the linear interpolation rate converter.
`timescale 1ns / 1ps
package lirc_pkg;

    // Default sizes of the sample path, the phase fraction and the run cap.
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int MAX_RUN_DEF     = 16;

    // Width and reset value of the phase step register.
    localparam int              STEP_W     = 20;
    localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;

    // Controls from the sequencer to the interpolation unit.
    typedef struct packed {
        logic load_first;   // first sample after reset: capture as older
        logic load_second;  // second sample: capture as newer
        logic load_shift;   // later samples: shift the pair
        logic mul;          // form the product for one output
    } t_dp_ctrl;

endpackage

// ----- design/lirc_interp_unit.sv -----
// Sample pair storage and the shared multiply unit for interpolation.
`timescale 1ns / 1ps
module lirc_interp_unit #(
    parameter int SAMPLE_BITS = lirc_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = lirc_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  lirc_pkg::t_dp_ctrl            i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [FRAC_BITS-1:0]          i_phase_frac,
    output logic signed [SAMPLE_BITS-1:0] o_result
);
    import lirc_pkg::*;

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    logic signed [SAMPLE_BITS-1:0] r_older;
    logic signed [SAMPLE_BITS-1:0] r_newer;
    logic signed [DIFF_W-1:0]      r_diff;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [DIFF_W-1:0]      sample_ext;
    logic signed [FRAC_BITS:0]     frac_signed;

    assign sample_ext  = DIFF_W'(i_sample);
    assign frac_signed = $signed({1'b0, i_phase_frac});

    // Pair registers updated on each input beat; the difference from the second beat on.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_first) begin
            r_older <= i_sample;
        end
        if (i_ctrl.load_second) begin
            r_newer <= i_sample;
            r_diff  <= sample_ext - DIFF_W'(r_older);
        end
        if (i_ctrl.load_shift) begin
            r_older <= r_newer;
            r_newer <= i_sample;
            r_diff  <= sample_ext - DIFF_W'(r_newer);
        end
        // One multiply per output, registered before the final add.
        if (i_ctrl.mul) begin
            r_prod <= r_diff * frac_signed;
        end
    end

    // Selecting the bits above the fraction floors the scaled difference; the sum wraps to sample width.
    assign o_result = r_older + $signed(r_prod[FRAC_BITS +: SAMPLE_BITS]);

endmodule

// ----- design/linear_interp_rate_converter.sv -----
// Top level of the push-model linear interpolation sample rate converter.
//
//  Channel   Handshake                    Payload
//  -------   --------------------------   -------------------------------
//  source    i_src_valid / o_src_ready    i_source_sample
//  result    o_out_valid / i_out_ready    o_out_sample, o_last_of_run
//  config    i_cfg_valid / o_cfg_ready    i_cfg_phase_step
//
// An input beat moves the sequencer from idle to multiply; each output then passes
// through the multiply, add and output beat states, using the single shared
// multiplier, and a run holds at most MAX_RUN outputs. A sample that yields none
// returns from the multiply state to idle. The first sample after reset only primes
// the pair; the second starts a run of outputs like any later sample. Source ready is
// low while a run is in progress; a stalled output beat holds the sequencer in place.
// Reset is synchronous and active low; the config port is always ready.
`timescale 1ns / 1ps
module linear_interp_rate_converter #(
    parameter int SAMPLE_BITS = lirc_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = lirc_pkg::FRAC_BITS_DEF,
    parameter int MAX_RUN     = lirc_pkg::MAX_RUN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Source sample channel
    input  logic                          i_src_valid,
    output logic                          o_src_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_source_sample,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_out_sample,
    output logic                          o_last_of_run,
    // Configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lirc_pkg::STEP_W-1:0]   i_cfg_phase_step
);
    import lirc_pkg::*;

    localparam int PHASE_BITS = FRAC_BITS + 4;
    localparam int RUN_W      = $clog2(MAX_RUN + 1);
    localparam logic [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(1) << FRAC_BITS;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    logic [1:0]                    r_state,     n_state;
    logic [1:0]                    r_prime,     n_prime;
    logic [PHASE_BITS-1:0]         r_phase,     n_phase;
    logic [RUN_W-1:0]              r_run,       n_run;
    logic                          r_last_pend, n_last_pend;
    logic                          r_out_valid, n_out_valid;
    logic                          r_out_last,  n_out_last;
    logic signed [SAMPLE_BITS-1:0] r_out_sample, n_out_sample;
    logic [STEP_W-1:0]             r_step;

    t_dp_ctrl                      dp_ctrl;
    logic signed [SAMPLE_BITS-1:0] dp_result;
    logic [PHASE_BITS-1:0]         step_trunc;
    logic [PHASE_BITS-1:0]         step_eff;
    logic [PHASE_BITS:0]           phase_sum;
    logic [PHASE_BITS-1:0]         phase_next;
    logic                          phase_ge_one;
    logic                          src_beat;

    lirc_interp_unit #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_interp (
        .i_clk        (i_clk),
        .i_ctrl       (dp_ctrl),
        .i_sample     (i_source_sample),
        .i_phase_frac (r_phase[FRAC_BITS-1:0]),
        .o_result     (dp_result)
    );

    // A zero step advances the phase by one LSB.
    assign step_trunc   = PHASE_BITS'(r_step);
    assign step_eff     = (step_trunc == '0) ? PHASE_BITS'(1) : step_trunc;
    // Phase advance saturates at all ones.
    assign phase_sum    = {1'b0, r_phase} + {1'b0, step_eff};
    assign phase_next   = phase_sum[PHASE_BITS] ? '1 : phase_sum[PHASE_BITS-1:0];
    assign phase_ge_one = |r_phase[PHASE_BITS-1:FRAC_BITS];

    assign o_src_ready = (r_state == S_IDLE);
    assign src_beat    = i_src_valid && o_src_ready;

    // Sequencer: priming, one multiply-add per output, then the output beat.
    always_comb begin
        n_state      = r_state;
        n_prime      = r_prime;
        n_phase      = r_phase;
        n_run        = r_run;
        n_last_pend  = r_last_pend;
        n_out_valid  = r_out_valid;
        n_out_last   = r_out_last;
        n_out_sample = r_out_sample;
        dp_ctrl      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (src_beat) begin
                    n_run = '0;
                    if (r_prime == 2'd0) begin
                        dp_ctrl.load_first = 1'b1;
                        n_prime            = 2'd1;
                    end else if (r_prime == 2'd1) begin
                        dp_ctrl.load_second = 1'b1;
                        n_prime             = 2'd2;
                        n_phase             = '0;
                        n_state             = S_MUL;
                    end else begin
                        // Drop one whole unit, saturating at zero after a capped run.
                        dp_ctrl.load_shift = 1'b1;
                        n_phase            = phase_ge_one ? (r_phase - PHASE_ONE) : '0;
                        n_state            = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (phase_ge_one) begin
                    // Downsampling: this sample yields no output.
                    n_state = S_IDLE;
                end else begin
                    dp_ctrl.mul = 1'b1;
                    n_phase     = phase_next;
                    n_last_pend = (|phase_next[PHASE_BITS-1:FRAC_BITS])
                                  || (r_run == RUN_W'(MAX_RUN - 1));
                    n_run       = r_run + RUN_W'(1);
                    n_state     = S_ADD;
                end
            end
            S_ADD: begin
                n_out_sample = dp_result;
                n_out_last   = r_last_pend;
                n_out_valid  = 1'b1;
                n_state      = S_WAIT;
            end
            S_WAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = r_last_pend ? S_IDLE : S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prime     <= 2'd0;
            r_phase     <= '0;
            r_run       <= '0;
            r_last_pend <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= STEP_RESET;
        end else begin
            r_state     <= n_state;
            r_prime     <= n_prime;
            r_phase     <= n_phase;
            r_run       <= n_run;
            r_last_pend <= n_last_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_step <= i_cfg_phase_step;
            end
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        r_out_sample <= n_out_sample;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_sample  = r_out_sample;
    assign o_last_of_run = r_out_last;
    assign o_cfg_ready   = 1'b1;

endmodule

// ----- sim/linear_interp_rate_converter_tb.sv -----
// Self-checking testbench for the linear interpolation sample rate converter.
`timescale 1ns / 1ps
module linear_interp_rate_converter_tb;

    localparam int SW      = lirc_pkg::SAMPLE_BITS_DEF;
    localparam int FW      = lirc_pkg::FRAC_BITS_DEF;
    localparam int RUN_CAP = lirc_pkg::MAX_RUN_DEF;
    localparam int PW      = lirc_pkg::STEP_W;

    localparam logic [PW-1:0] PHASE_ONE      = PW'(1) << FW;
    localparam logic [PW-1:0] STEP_UNITY     = PW'(1) << FW;
    localparam logic [PW-1:0] STEP_FINEST    = PW'(4096);
    localparam logic [PW-1:0] STEP_COARSEST  = PW'(524288);
    localparam logic [PW-1:0] STEP_ALL_ONES  = '1;
    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    // A sample that yields no output still keeps the block busy in the multiply state.
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 last;
    } t_interp_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_src_valid;
    logic                 o_src_ready;
    logic signed [SW-1:0] i_source_sample;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [SW-1:0] o_out_sample;
    logic                 o_last_of_run;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [PW-1:0]        i_cfg_phase_step;

    // Shadow state of the interpolator.
    logic signed [SW-1:0] model_older;
    logic signed [SW-1:0] model_newer;
    logic [PW-1:0]        model_phase;
    logic [PW-1:0]        model_step;
    int                   model_primed;

    t_interp_result pending_outputs[$];
    int             mismatch_count = 0;
    int             src_idle_pct   = 0;
    int             rx_stall_pct   = 0;
    int             rx_hold_left   = 0;
    int             stall_cycles   = 0;

    linear_interp_rate_converter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_src_valid      (i_src_valid),
        .o_src_ready      (o_src_ready),
        .i_source_sample  (i_source_sample),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_sample     (o_out_sample),
        .o_last_of_run    (o_last_of_run),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_phase_step (i_cfg_phase_step)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: a long hold-off when requested, otherwise random stalls.
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_out_ready  <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Compare each output beat with the oldest predicted sample.
    always @(negedge i_clk) begin
        t_interp_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: unexpected output beat, sample %0d last %0b",
                         $time, o_out_sample, o_last_of_run);
                mismatch_count++;
            end else begin
                want = pending_outputs.pop_front();
                if (o_out_sample !== want.sample) begin
                    $display("%0t: out_sample expected %0d, got %0d",
                             $time, want.sample, o_out_sample);
                    mismatch_count++;
                end
                if (o_last_of_run !== want.last) begin
                    $display("%0t: last_of_run expected %0b, got %0b",
                             $time, want.last, o_last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    always @(negedge i_clk) begin
        if (!i_rst_n || (i_src_valid && o_src_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Shift one accepted source sample into the shadow state and queue the
    // interpolated outputs that it produces.
    task automatic predict_interp_run(input logic signed [SW-1:0] s);
        logic [PW-1:0]  eff_step;
        logic [PW:0]    phase_sum;
        longint         diff;
        longint         prod;
        t_interp_result r;
        int             n;
        eff_step = (model_step == '0) ? PW'(1) : model_step;
        n = 0;
        if (model_primed == 0) begin
            model_older  = s;
            model_primed = 1;
        end else begin
            if (model_primed == 1) begin
                model_newer  = s;
                model_phase  = '0;
                model_primed = 2;
            end else begin
                model_older = model_newer;
                model_newer = s;
                // Only a capped run can leave the phase below one here.
                model_phase = (model_phase >= PHASE_ONE) ? model_phase - PHASE_ONE : '0;
            end
            while (model_phase < PHASE_ONE && n < RUN_CAP) begin
                diff      = longint'(model_newer) - longint'(model_older);
                prod      = diff * longint'(model_phase);
                r.sample  = SW'(longint'(model_older) + (prod >>> FW));
                phase_sum = {1'b0, model_phase} + {1'b0, eff_step};
                model_phase = phase_sum[PW] ? STEP_ALL_ONES : phase_sum[PW-1:0];
                r.last    = (model_phase >= PHASE_ONE) || (n == RUN_CAP - 1);
                pending_outputs.push_back(r);
                n++;
            end
        end
    endtask

    // Offer one source sample, with random idle cycles ahead of it.
    task automatic send_sample(input logic signed [SW-1:0] s);
        logic rdy;
        while ($urandom_range(99) < src_idle_pct) begin
            i_src_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_src_valid     <= 1'b1;
        i_source_sample <= s;
        do begin
            @(negedge i_clk);
            rdy = o_src_ready;
            @(posedge i_clk);
        end while (!rdy);
        predict_interp_run(s);
    endtask

    // Stop offering samples and let every predicted output arrive.
    task automatic wait_drained();
        i_src_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_phase_step(input logic [PW-1:0] step);
        logic rdy;
        wait_drained();
        i_cfg_valid      <= 1'b1;
        i_cfg_phase_step <= step;
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        model_step = step;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int src_pct, input int rx_pct);
        i_src_valid <= 1'b0;
        @(negedge i_clk);
        src_idle_pct = src_pct;
        rx_stall_pct = rx_pct;
        @(posedge i_clk);
    endtask

    function automatic logic signed [SW-1:0] random_sample();
        logic signed [SW-1:0] v;
        case ($urandom_range(7))
            0: v = SAMPLE_MAX;
            1: v = SAMPLE_MIN;
            2: v = SW'(int'($urandom_range(64)) - 32);
            default: v = SW'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [PW-1:0] random_step();
        logic [PW-1:0] v;
        case ($urandom_range(9))
            0: v = STEP_FINEST;
            1: v = STEP_COARSEST;
            2: v = STEP_UNITY;
            3: v = '0;
            4: v = ($urandom_range(3) == 0) ? STEP_ALL_ONES : PW'($urandom);
            default: v = PW'($urandom_range(4096, 524288));
        endcase
        return v;
    endfunction

    // Random samples, with a fresh step setting every ten of them.
    task automatic run_random_samples(input int n_samples);
        for (int i = 0; i < n_samples; i++) begin
            if (i % 10 == 0) write_phase_step(random_step());
            send_sample(random_sample());
        end
    endtask

    // Priming on the first two samples, then unity steps across full-scale swings.
    task automatic test_priming_unity();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(SW'(-1));
        send_sample(SW'(1));
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SW'(24'h555555));
        send_sample(SW'(24'haaaaaa));
    endtask

    // The finest step fills a run exactly; a zero step hits the run cap.
    task automatic test_run_cap();
        write_phase_step(STEP_FINEST);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SW'(12345));
        write_phase_step('0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SW'(100));
    endtask

    // Phase left below one after a capped run, phase overflow, downsampling.
    task automatic test_phase_limits();
        write_phase_step(PW'(40000));
        send_sample(SW'(-4000));
        send_sample(SW'(7000));
        write_phase_step(STEP_ALL_ONES);
        repeat (5) send_sample(random_sample());
        write_phase_step(STEP_COARSEST);
        repeat (3) send_sample(random_sample());
    endtask

    task automatic test_random_streaming();
        set_idling(0, 0);
        run_random_samples(80);
    endtask

    task automatic test_random_sender_idle();
        set_idling(79, 0);
        run_random_samples(55);
    endtask

    task automatic test_random_receiver_stall();
        set_idling(0, 79);
        run_random_samples(55);
    endtask

    task automatic test_random_both_idle();
        set_idling(16, 16);
        run_random_samples(55);
    endtask

    // Receiver holds off while the sender keeps offering long runs.
    task automatic test_output_backpressure();
        set_idling(0, 0);
        write_phase_step(STEP_FINEST);
        @(negedge i_clk);
        rx_hold_left = 400;
        @(posedge i_clk);
        repeat (12) send_sample(random_sample());
        wait_drained();
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_src_valid      <= 1'b0;
        i_source_sample  <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_phase_step <= '0;
        model_older  = '0;
        model_newer  = '0;
        model_phase  = '0;
        model_step   = lirc_pkg::STEP_RESET;
        model_primed = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_priming_unity();
        test_run_cap();
        test_phase_limits();
        test_random_streaming();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_output_backpressure();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (pending_outputs.size() != 0) begin
            $display("%0t: %0d predicted outputs never arrived",
                     $time, pending_outputs.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/lirc_pkg.sv
design/lirc_interp_unit.sv
design/linear_interp_rate_converter.sv
sim/linear_interp_rate_converter_tb.sv
